### hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante implies cons in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dtyp_pkg.sv
package dtyp_pkg;

   localparam int COMP_W      = 24;
   localparam int GUARD_BITS  = 26;
   localparam int FRAC_BITS   = 7;
   localparam int STAGES      = 18;
   localparam int ANG_SHIFT   = 24;
   localparam int OUT_W       = 16;
   localparam int CW          = 56;
   localparam int AW          = 33;
   localparam int GAIN_W      = 31;
   localparam int ZK_W        = COMP_W + GAIN_W - (30 - GUARD_BITS);
   localparam int RND_SHIFT   = ANG_SHIFT - FRAC_BITS;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_W     = $clog2(Q_DEPTH);

   localparam logic signed [AW-1:0] DEG90  = AW'(90) <<< ANG_SHIFT;
   localparam logic signed [AW-1:0] DEG180 = AW'(180) <<< ANG_SHIFT;
   localparam logic signed [AW-1:0] DEG270 = AW'(270) <<< ANG_SHIFT;
   localparam logic signed [AW-1:0] DEG360 = AW'(360) <<< ANG_SHIFT;
   localparam logic [OUT_W-1:0] FULL_TURN = OUT_W'(360 << FRAC_BITS);

   // atan(2^-i) in degrees * 2^24
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
      32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
      32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
      32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
      32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
   };

   // cordic gain in q30, sqrt of prod(1 + 4^-i), computed at elaboration
   function automatic logic [63:0] gain_q30_f();
      logic [63:0] k2;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      k2 = 64'd1 << 30;
      for (int i = 0; i < STAGES; i++) begin
         k2 = k2 + (k2 >> (2 * i));
      end
      v = k2 << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(gain_q30_f());

   typedef struct packed {
      logic [COMP_W-1:0] ax;
      logic [COMP_W-1:0] ay;
      logic [ZK_W-1:0]   zk;
      logic              x_neg;
      logic              y_neg;
      logic              z_neg;
      logic              z_pos;
      logic              xy_zero;
   } item_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] ang;
      logic signed [AW-1:0] th;
      logic [ZK_W-1:0]      zk;
      logic                 x_neg;
      logic                 y_neg;
      logic                 z_neg;
      logic                 z_pos;
      logic                 xy_zero;
   } stage_type;

   function automatic logic signed [AW-1:0] clamp_f(logic signed [AW-1:0] a);
      logic signed [AW-1:0] r;
      r = a;
      if (a < 0) r = '0;
      if (a > DEG90) r = DEG90;
      return r;
   endfunction

   // one vectoring micro-rotation, shift amount fixed per stage
   function automatic stage_type rot_f(stage_type s, int unsigned i);
      stage_type o;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [AW-1:0] da;
      o  = s;
      dx = s.y >>> i;
      dy = s.x >>> i;
      da = $signed({1'b0, ATAN_TAB[i[4:0]]});
      if (!s.y[CW-1]) begin
         o.x   = s.x + dx;
         o.y   = s.y - dy;
         o.ang = s.ang + da;
      end else begin
         o.x   = s.x - dx;
         o.y   = s.y + dy;
         o.ang = s.ang - da;
      end
      return o;
   endfunction

   // round half up to output scale, 360 wraps to 0
   function automatic logic [OUT_W-1:0] finish_f(logic signed [AW-1:0] a);
      logic [AW-1:0]    rnd;
      logic [OUT_W-1:0] r;
      rnd = $unsigned(a) + (AW'(1) << (RND_SHIFT - 1));
      r   = OUT_W'(rnd >> RND_SHIFT);
      if (r >= FULL_TURN) r = r - FULL_TURN;
      return r;
   endfunction

endpackage

### hdl/dtyp_front.sv
module dtyp_front
   import dtyp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [3*COMP_W-1:0]  in_data,
   output logic                 item_valid,
   input  logic                 item_ready,
   output item_type             item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic signed [COMP_W-1:0] x, y, z;
   logic [COMP_W+GAIN_W-1:0] zprod;

   always_comb begin
      x = $signed(in_data[COMP_W-1:0]);
      y = $signed(in_data[2*COMP_W-1:COMP_W]);
      z = $signed(in_data[3*COMP_W-1:2*COMP_W]);
      item_in.ax = x[COMP_W-1] ? COMP_W'(-x) : COMP_W'(x);
      item_in.ay = y[COMP_W-1] ? COMP_W'(-y) : COMP_W'(y);
      zprod = (z[COMP_W-1] ? COMP_W'(-z) : COMP_W'(z)) * GAIN;
      item_in.zk = ZK_W'(zprod >> (30 - GUARD_BITS));
      item_in.x_neg = x[COMP_W-1];
      item_in.y_neg = y[COMP_W-1];
      item_in.z_neg = z[COMP_W-1];
      item_in.z_pos = !z[COMP_W-1] && (z != '0);
      item_in.xy_zero = (x == '0) && (y == '0);
   end

   assign in_ready   = !valid_ff || item_ready;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

### hdl/dtyp_queue.sv
`include "assert_macros.svh"

module dtyp_queue
   import dtyp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign push_ready = (cnt_ff != (Q_PTR_W+1)'(Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > (Q_PTR_W+1)'(Q_DEPTH), "queue count out of range")
   `ASSERT_NEVER(a_ptr_sync, clock, reset, Q_PTR_W'(wr_ff - rd_ff) != cnt_ff[Q_PTR_W-1:0], "queue pointers disagree with count")
   `ASSERT_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "push lost")

endmodule

### hdl/dtyp_back.sv
`include "assert_macros.svh"

module dtyp_back
   import dtyp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  item_type         in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [OUT_W-1:0] pitch,
   output logic [OUT_W-1:0] yaw
);

   stage_type p1_ff [STAGES];
   stage_type p2_ff [STAGES];
   logic      v1_ff [STAGES];
   logic      v2_ff [STAGES];
   stage_type s1_init, s2_init;
   logic             out_v_ff;
   logic [OUT_W-1:0] pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic             en;
   logic signed [AW-1:0] ph, yaw_a, pitch_a;

   // whole pipeline stalls only when the output word is held
   assign en       = !out_v_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      s1_init.x       = CW'({in_item.ax, GUARD_BITS'(0)});
      s1_init.y       = CW'({in_item.ay, GUARD_BITS'(0)});
      s1_init.ang     = '0;
      s1_init.th      = '0;
      s1_init.zk      = in_item.zk;
      s1_init.x_neg   = in_item.x_neg;
      s1_init.y_neg   = in_item.y_neg;
      s1_init.z_neg   = in_item.z_neg;
      s1_init.z_pos   = in_item.z_pos;
      s1_init.xy_zero = in_item.xy_zero;
      // second pass: radius from first pass against gain-scaled |z|
      s2_init     = p1_ff[STAGES-1];
      s2_init.th  = clamp_f(p1_ff[STAGES-1].ang);
      s2_init.y   = CW'(p1_ff[STAGES-1].zk);
      s2_init.ang = '0;
   end

   genvar k;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         always_ff @(posedge clock) begin
            if (reset) begin
               v1_ff[k] <= 1'b0;
               v2_ff[k] <= 1'b0;
            end else if (en) begin
               v1_ff[k] <= (k == 0) ? in_valid : v1_ff[(k == 0) ? 0 : k-1];
               v2_ff[k] <= (k == 0) ? v1_ff[STAGES-1] : v2_ff[(k == 0) ? 0 : k-1];
            end
            if (en) begin
               p1_ff[k] <= rot_f((k == 0) ? s1_init : p1_ff[(k == 0) ? 0 : k-1], k);
               p2_ff[k] <= rot_f((k == 0) ? s2_init : p2_ff[(k == 0) ? 0 : k-1], k);
            end
         end
      end
   endgenerate

   always_comb begin
      ph = clamp_f(p2_ff[STAGES-1].ang);
      if (!p2_ff[STAGES-1].x_neg) begin
         yaw_a = p2_ff[STAGES-1].y_neg ? DEG360 - p2_ff[STAGES-1].th : p2_ff[STAGES-1].th;
      end else begin
         yaw_a = p2_ff[STAGES-1].y_neg ? DEG180 + p2_ff[STAGES-1].th
                                       : DEG180 - p2_ff[STAGES-1].th;
      end
      pitch_a = p2_ff[STAGES-1].z_neg ? DEG360 - ph : ph;
      if (p2_ff[STAGES-1].xy_zero) begin
         yaw_a   = '0;
         pitch_a = p2_ff[STAGES-1].z_pos ? DEG90 : DEG270;
      end
      pitch_in = finish_f(pitch_a);
      yaw_in   = finish_f(yaw_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v2_ff[STAGES-1];
      end
      if (en) begin
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign out_valid = out_v_ff;
   assign pitch     = pitch_ff;
   assign yaw       = yaw_ff;

   `ASSERT_NEVER(a_pitch_range, clock, reset, out_v_ff && (pitch_ff >= FULL_TURN), "pitch out of range")
   `ASSERT_NEVER(a_yaw_range, clock, reset, out_v_ff && (yaw_ff >= FULL_TURN), "yaw out of range")
   `ASSERT_NEXT(a_stall_keep, clock, reset, !en, v2_ff[STAGES-1] == $past(v2_ff[STAGES-1]), "stage moved during stall")

endmodule

### hdl/direction_to_yaw_pitch.sv
// path from req word accepted to rsp word valid: front register (loads on the
//   accepting edge), queue, two 18-stage cordic passes, angle finish register
// throughput: one word per cycle while rsp_tready stays high; the cordic pipeline
//   halts as a whole only while the output word waits, the queue keeps taking words
//   until it fills
// reset: synchronous, active high; clears all valid flags and queue pointers
module direction_to_yaw_pitch
   import dtyp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [3*COMP_W-1:0] req_tdata,  // fwd_x, fwd_y, fwd_z
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2*OUT_W-1:0]  rsp_tdata   // pitch_deg, yaw_deg
);

   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;
   logic [OUT_W-1:0] pitch, yaw;

   dtyp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   dtyp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   dtyp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .pitch     (pitch),
      .yaw       (yaw)
   );

   assign rsp_tdata = {yaw, pitch};

endmodule
